// ===== hdl/upd_pkg.sv =====
// Package for the URL path decode and normalize block.
// Holds the character codes, the hex helpers and the structs passed between modules.
// No dependencies.
package upd_pkg;

   // Character codes
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Room for the decoded bytes one raw byte can release (at most three: a broken escape, a new '%'
   // and its flush at the end of the target), and most results per item
   localparam int unsigned DEC_SLOTS = 4;
   localparam int unsigned RES_SLOTS = 4;

   // Decoded bytes released by one raw byte, in order
   typedef struct packed {
      logic [2:0]                       count;
      logic [DEC_SLOTS-1:0][7:0]        bytes;
      logic                             last;
   } upd_dec_type;

   // Results caused by one raw byte, in order
   typedef struct packed {
      logic [2:0]                       count;
      logic [RES_SLOTS-1:0][7:0]        bytes;
      logic [RES_SLOTS-1:0]             has;
      logic                             path_end;
   } upd_res_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // Value of a hex digit; letters map through their low nibble plus nine
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] v;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c[3:0];
      end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
         v = c[3:0] + 4'd9;
      end else begin
         v = 4'd0;
      end
      return v;
   endfunction

endpackage

// ===== hdl/upd_if.sv =====
// Stream interfaces for the raw target bytes and the normalized path results.
// Depends on nothing.
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       path_end;
   logic       run_last;

   modport source (output valid, output out_byte, output has_byte, output path_end,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input path_end,
                   input run_last, output ready);
endinterface

// ===== hdl/url_path_decode_normalize.sv =====
// Path: an accepted byte is held in the input register; its results then load the result register.
// Throughput: one byte per cycle while each byte gives at most one result and the output is ready; a byte
// that gives k results (up to four) holds the result register for k transfers.
// Reset (synchronous, active high) empties both registers and clears the state.
// Top level of the URL path decoder; depends on upd_pkg, the stream interfaces,
// upd_decode, upd_norm and upd_outq.
module url_path_decode_normalize import upd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_ch,
   upd_rsp_if.source rsp_ch
);

   logic        vld_ff, vld_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic        free;
   logic        advance;
   logic        req_xfer;
   upd_dec_type dec;
   upd_res_type res;

   // Consume the held byte when the result register can take its results
   assign advance      = vld_ff && free;
   assign req_ch.ready = !vld_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (req_xfer) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Capture the input payload on each transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         byte_ff <= req_ch.in_byte;
         last_ff <= req_ch.in_last;
      end
   end

   upd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .raw_byte (byte_ff),
      .raw_last (last_ff),
      .dec      (dec)
   );

   upd_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .dec     (dec),
      .res     (res)
   );

   upd_outq u_outq (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .res    (res),
      .free   (free),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== hdl/upd_decode.sv =====
// Percent decoder: escape state registers and the logic that turns one raw byte
// into up to three decoded bytes. Depends on upd_pkg.
module upd_decode import upd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [7:0]  raw_byte,
   input  logic        raw_last,
   output upd_dec_type dec
);

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_PCT,
      ESC_HEX
   } esc_type;

   esc_type    phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   // Release decoded bytes and work out the next escape state
   always_comb begin
      logic [2:0] n;
      logic       do_idle;
      logic       hex;
      n        = 3'd0;
      do_idle  = 1'b0;
      hex      = is_hex(raw_byte);
      dec      = '0;
      phase_in = phase_ff;
      held_in  = held_ff;

      unique case (phase_ff)
         ESC_PCT: begin
            if (hex) begin
               held_in  = raw_byte;
               phase_in = ESC_HEX;
            end else begin
               phase_in          = ESC_IDLE;
               dec.bytes[n[1:0]] = CH_PCT;
               n                 = n + 3'd1;
               do_idle           = 1'b1;
            end
         end
         ESC_HEX: begin
            held_in  = CH_NUL;
            phase_in = ESC_IDLE;
            if (hex) begin
               dec.bytes[n[1:0]] = {hex_nibble(held_ff), hex_nibble(raw_byte)};
               n                 = n + 3'd1;
            end else begin
               dec.bytes[n[1:0]] = CH_PCT;
               n                 = n + 3'd1;
               dec.bytes[n[1:0]] = held_ff;
               n                 = n + 3'd1;
               do_idle           = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      // Byte seen with no escape pending
      if (do_idle) begin
         if (raw_byte == CH_PCT) begin
            phase_in = ESC_PCT;
         end else if (raw_byte == CH_PLUS) begin
            dec.bytes[n[1:0]] = CH_SPACE;
            n                 = n + 3'd1;
         end else begin
            dec.bytes[n[1:0]] = raw_byte;
            n                 = n + 3'd1;
         end
      end

      // Flush a pending escape literally at the end of the target
      if (raw_last) begin
         if (phase_in == ESC_PCT) begin
            dec.bytes[n[1:0]] = CH_PCT;
            n                 = n + 3'd1;
         end else if (phase_in == ESC_HEX) begin
            dec.bytes[n[1:0]] = CH_PCT;
            n                 = n + 3'd1;
            dec.bytes[n[1:0]] = held_in;
            n                 = n + 3'd1;
         end
         phase_in = ESC_IDLE;
         held_in  = CH_NUL;
      end

      dec.count = n;
      dec.last  = raw_last;
   end

   // Hold escape state; advance once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ESC_IDLE;
         held_ff  <= CH_NUL;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== hdl/upd_norm.sv =====
// Path normalizer: leading slash, backslash mapping, truncation at '?' or '#'
// and slash collapsing over up to four decoded bytes. Depends on upd_pkg.
module upd_norm import upd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  upd_dec_type dec,
   output upd_res_type res
);

   logic start_ff, start_in;
   logic prev_ff, prev_in;
   logic trunc_ff, trunc_in;

   // Walk the decoded bytes in order and collect the results
   always_comb begin
      logic [2:0] cnt;
      logic       start;
      logic       prev;
      logic       trunc;
      logic [7:0] c;
      cnt   = 3'd0;
      start = start_ff;
      prev  = prev_ff;
      trunc = trunc_ff;
      c     = CH_NUL;
      res   = '0;

      for (int i = 0; i < DEC_SLOTS; i++) begin
         if ((3'(i) < dec.count) && !trunc) begin
            if (start) begin
               if (cnt < 3'(RES_SLOTS)) begin
                  res.bytes[cnt[1:0]] = CH_SLASH;
                  res.has[cnt[1:0]]   = 1'b1;
                  cnt                 = cnt + 3'd1;
               end
               start = 1'b0;
               prev  = 1'b1;
            end
            c = (dec.bytes[i] == CH_BSLASH) ? CH_SLASH : dec.bytes[i];
            if ((c == CH_QMARK) || (c == CH_HASH)) begin
               trunc = 1'b1;
            end else if (c == CH_SLASH) begin
               if (!prev && (cnt < 3'(RES_SLOTS))) begin
                  res.bytes[cnt[1:0]] = CH_SLASH;
                  res.has[cnt[1:0]]   = 1'b1;
                  cnt                 = cnt + 3'd1;
               end
               prev = 1'b1;
            end else begin
               if (cnt < 3'(RES_SLOTS)) begin
                  res.bytes[cnt[1:0]] = c;
                  res.has[cnt[1:0]]   = 1'b1;
                  cnt                 = cnt + 3'd1;
               end
               prev = 1'b0;
            end
         end
      end

      // End-only marker when the final byte gives no path byte
      if (dec.last && (cnt == 3'd0)) begin
         cnt = 3'd1;
      end

      res.count    = cnt;
      res.path_end = dec.last;

      // Return to the start of a new target after the final byte
      if (dec.last) begin
         start_in = 1'b1;
         prev_in  = 1'b0;
         trunc_in = 1'b0;
      end else begin
         start_in = start;
         prev_in  = prev;
         trunc_in = trunc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         prev_ff  <= 1'b0;
         trunc_ff <= 1'b0;
      end else if (advance) begin
         start_ff <= start_in;
         prev_ff  <= prev_in;
         trunc_ff <= trunc_in;
      end
   end

endmodule

// ===== hdl/upd_outq.sv =====
// Result register: holds the results of one byte and sends them one per transfer.
// Depends on upd_pkg and upd_rsp_if.
module upd_outq import upd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  upd_res_type   res,
   output logic          free,
   upd_rsp_if.source     rsp_ch
);

   logic [RES_SLOTS-1:0][7:0] bytes_ff;
   logic [RES_SLOTS-1:0]      has_ff;
   logic [2:0]                cnt_ff, cnt_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      end_ff;
   logic                      final_one;
   logic                      xfer;

   assign final_one = ({1'b0, idx_ff} + 3'd1) == cnt_ff;
   assign xfer      = rsp_ch.valid && rsp_ch.ready;
   assign free      = (cnt_ff == 3'd0) || (xfer && final_one);

   // Present the current entry
   assign rsp_ch.valid    = cnt_ff != 3'd0;
   assign rsp_ch.out_byte = bytes_ff[idx_ff];
   assign rsp_ch.has_byte = has_ff[idx_ff];
   assign rsp_ch.run_last = final_one;
   assign rsp_ch.path_end = end_ff && final_one;

   // Advance through the entries; reload when empty or when the last one leaves
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (xfer) begin
         if (final_one) begin
            cnt_in = 3'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load && free) begin
         cnt_in = res.count;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load && free) begin
         bytes_ff <= res.bytes;
         has_ff   <= res.has;
         end_ff   <= res.path_end;
      end
   end

endmodule

// ===== hdl/upd_checker.sv =====
// Port checker for url_path_decode_normalize, bound to the top level.
// Depends on nothing but the top level's ports.
module upd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic       rsp_path_end,
   input logic       rsp_run_last
);

   // No result is offered in the cycle after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // An end-only marker carries a zero byte and closes the path
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_out_byte == 8'h00) && rsp_path_end)
      else $error("malformed end-only marker");

   // The end of a path is always the last result of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_path_end) |-> rsp_run_last)
      else $error("path end without run end");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_has_byte) && $stable(rsp_path_end) && $stable(rsp_run_last))
      else $error("stalled result changed");

endmodule

bind url_path_decode_normalize upd_checker u_upd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_byte (rsp_ch.out_byte),
   .rsp_has_byte (rsp_ch.has_byte),
   .rsp_path_end (rsp_ch.path_end),
   .rsp_run_last (rsp_ch.run_last)
);
